// ===== hdl/spc_pkg.sv =====
// Shared types and constants for the segment pair closest points block.
// No dependencies; imported by every module of the block.
`default_nettype none

package spc_pkg;

  localparam int unsigned CW       = 32;          // coordinate width, Q16.16
  localparam int unsigned DW       = CW + 1;      // endpoint differences
  localparam int unsigned PW       = 2 * DW;      // signed product of two differences
  localparam int unsigned XW       = PW + 1;      // signed cross product component
  localparam int unsigned MW       = PW;          // cross product magnitude
  localparam int unsigned Q_FRAC   = 16;
  localparam int unsigned NW       = MW + Q_FRAC; // scaled numerator magnitude
  localparam int unsigned QW       = 56;          // quotient bits before saturation
  localparam int unsigned RW       = QW + 1;      // signed ratio
  localparam int unsigned SW       = RW + 2;      // sum of up to three ratios
  localparam int unsigned TW       = Q_FRAC + 1;  // clamped parameter, 0..1.0
  localparam int unsigned SCW      = TW + 1 + DW; // parameter times difference
  localparam int unsigned EPS_W    = 31;
  localparam int unsigned SQW      = 2 * CW;      // square root radicand
  localparam int unsigned DIV_LAT  = QW + 3;
  localparam int unsigned SQ_STEPS = CW;
  localparam int unsigned SQ_LAT   = SQ_STEPS + 1;
  localparam int unsigned AVG_W    = TW + 1;
  localparam int unsigned RECIP_SH = 19;
  localparam logic [AVG_W-1:0] RECIP3 = AVG_W'(174763); // ceil(2^19 / 3)
  localparam logic [TW-1:0] ONE_Q  = TW'(65536);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

  localparam int unsigned CFG_AW  = 3;
  localparam logic        REG_EPS = 1'b0;

  localparam int unsigned AX1 [3] = '{1, 2, 0};
  localparam int unsigned AX2 [3] = '{2, 0, 1};

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DW-1:0]  diff_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [XW-1:0]  cross_t;
  typedef logic signed [RW-1:0]  ratio_t;

  typedef struct {
    coord_t as [3];
    coord_t ae [3];
    coord_t bs [3];
    coord_t be [3];
  } seg_t;

  typedef struct {
    coord_t as [3];
    coord_t bs [3];
    diff_t  d1 [3];
    diff_t  d2 [3];
  } geo_t;

  typedef struct {
    geo_t       geo;
    cross_t     c1 [3];
    cross_t     c2 [3];
    cross_t     cl [3];
    logic [2:0] mask;
  } mid_t;

  typedef struct {
    logic             vres;
    coord_t           na [3];
    coord_t           nb [3];
    logic [CW-1:0]    gap;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/spc_div.sv =====
// Pipelined restoring divider: Q16.16 ratio of two cross product components,
// truncated toward zero and saturated. One quotient bit per stage. Uses spc_pkg.
`default_nettype none

module spc_div import spc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   en_i,
  input  wire cross_t num_i,
  input  wire cross_t den_i,
  output ratio_t      q_o
);

  logic            neg0_q;
  logic [NW-1:0]   n0_q;
  logic [MW-1:0]   d0_q;

  logic [MW-1:0]   rem_q [QW+1];
  logic [QW-1:0]   nl_q  [QW+1];
  logic [QW-1:0]   qb_q  [QW+1];
  logic [MW-1:0]   dv_q  [QW+1];
  logic            neg_q [QW+1];
  logic            ovf_q [QW+1];

  ratio_t          q_q;
  cross_t          absn, absd;
  logic [QW-1:0]   mag;

  assign absn = num_i[XW-1] ? -num_i : num_i;
  assign absd = den_i[XW-1] ? -den_i : den_i;
  assign mag  = ovf_q[QW] ? {QW{1'b1}} : qb_q[QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg0_q <= num_i[XW-1] ^ den_i[XW-1];
      n0_q   <= {MW'(absn), {Q_FRAC{1'b0}}};
      d0_q   <= MW'(absd);
      rem_q[0] <= MW'(n0_q >> QW);
      nl_q[0]  <= n0_q[QW-1:0];
      qb_q[0]  <= '0;
      dv_q[0]  <= d0_q;
      neg_q[0] <= neg0_q;
      ovf_q[0] <= {d0_q, {QW{1'b0}}} <= (MW+QW)'(n0_q);
      q_q <= neg_q[QW] ? -RW'(mag) : RW'(mag);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [MW:0] r2;
    logic        ge;
    assign r2 = {rem_q[j-1], nl_q[j-1][QW-1]};
    assign ge = r2 >= {1'b0, dv_q[j-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? MW'(r2 - {1'b0, dv_q[j-1]}) : MW'(r2);
        nl_q[j]  <= {nl_q[j-1][QW-2:0], 1'b0};
        qb_q[j]  <= {qb_q[j-1][QW-2:0], ge};
        dv_q[j]  <= dv_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// ===== hdl/spc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Uses spc_pkg.
`default_nettype none

module spc_sqrt import spc_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [SQW-1:0] x_i,
  output logic [CW-1:0]       r_o
);

  logic [SQW-1:0] sn_q [SQ_STEPS+1];
  logic [SQW-1:0] sr_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q[0] <= x_i;
      sr_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_step
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 * j);
    logic [SQW-1:0] cand;
    assign cand = sr_q[j-1] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sn_q[j-1] >= cand) begin
          sn_q[j] <= sn_q[j-1] - cand;
          sr_q[j] <= (sr_q[j-1] >> 1) + BIT;
        end else begin
          sn_q[j] <= sn_q[j-1];
          sr_q[j] <= sr_q[j-1] >> 1;
        end
      end
    end
  end

  assign r_o = sr_q[SQ_STEPS][CW-1:0];

endmodule

`default_nettype wire

// ===== hdl/spc_front.sv =====
// Front end: takes segment pairs, forms differences and cross products and
// marks the axes whose direction cross product clears epsilon. Uses spc_pkg.
`default_nettype none

module spc_front import spc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire seg_t             seg_i,
  input  wire logic [EPS_W-1:0] eps_i,
  output logic                  mid_vld_o,
  output mid_t                  mid_o,
  input  wire logic             mid_rdy_i
);

  logic   en;
  logic   a_v_q, b_v_q, c_v_q, d_v_q;
  geo_t   geo_a_q, geo_b_q, geo_c_q;
  diff_t  w_q [3];
  prod_t  p1a_q [3], p1b_q [3], p2a_q [3], p2b_q [3], pla_q [3], plb_q [3];
  cross_t c1_q [3], c2_q [3], cl_q [3];
  mid_t   mid_q;

  assign en     = !d_v_q || mid_rdy_i;
  assign full_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= push_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        geo_a_q.as[k] <= seg_i.as[k];
        geo_a_q.bs[k] <= seg_i.bs[k];
        geo_a_q.d1[k] <= DW'(seg_i.ae[k]) - DW'(seg_i.as[k]);
        geo_a_q.d2[k] <= DW'(seg_i.be[k]) - DW'(seg_i.bs[k]);
        w_q[k]        <= DW'(seg_i.bs[k]) - DW'(seg_i.as[k]);

        p1a_q[k] <= w_q[AX1[k]] * geo_a_q.d2[AX2[k]];
        p1b_q[k] <= w_q[AX2[k]] * geo_a_q.d2[AX1[k]];
        p2a_q[k] <= w_q[AX1[k]] * geo_a_q.d1[AX2[k]];
        p2b_q[k] <= w_q[AX2[k]] * geo_a_q.d1[AX1[k]];
        pla_q[k] <= geo_a_q.d1[AX1[k]] * geo_a_q.d2[AX2[k]];
        plb_q[k] <= geo_a_q.d1[AX2[k]] * geo_a_q.d2[AX1[k]];

        c1_q[k] <= XW'(p1a_q[k]) - XW'(p1b_q[k]);
        c2_q[k] <= XW'(p2a_q[k]) - XW'(p2b_q[k]);
        cl_q[k] <= XW'(pla_q[k]) - XW'(plb_q[k]);

        mid_q.c1[k]   <= c1_q[k];
        mid_q.c2[k]   <= c2_q[k];
        mid_q.cl[k]   <= cl_q[k];
        mid_q.mask[k] <= MW'(cl_q[k][XW-1] ? -cl_q[k] : cl_q[k]) > MW'(eps_i);
      end
      geo_b_q   <= geo_a_q;
      geo_c_q   <= geo_b_q;
      mid_q.geo <= geo_c_q;
    end
  end

  assign mid_vld_o = d_v_q;
  assign mid_o     = mid_q;

endmodule

`default_nettype wire

// ===== hdl/spc_mq.sv =====
// Two-entry queue between front and back ends.
// Uses spc_pkg.
`default_nettype none

module spc_mq import spc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire mid_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output mid_t      data_o
);

  mid_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wp_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== hdl/spc_back.sv =====
// Back end: ratio division, averaging and clamping, point forming and
// distance, with a two-entry result queue. Uses spc_pkg, spc_div, spc_sqrt.
`default_nettype none

module spc_back import spc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_vld_i,
  input  wire mid_t mid_i,
  output logic      in_rdy_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_t      out_o
);

  typedef struct {
    geo_t       geo;
    logic [2:0] mask;
  } side_t;

  typedef struct {
    coord_t pa [3];
    coord_t pb [3];
    logic   vr;
    logic   sat;
  } pt_t;

  function automatic logic [TW-1:0] avg_t(input logic signed [SW-1:0] s,
                                          input logic [1:0] n);
    logic [AVG_W-1:0]   x;
    logic [2*AVG_W-1:0] pr;
    logic [TW-1:0]      t;
    x  = s[AVG_W-1:0];
    pr = (2*AVG_W)'(x) * (2*AVG_W)'(RECIP3);
    t  = '0;
    priority if (s[SW-1]) begin
      t = '0;
    end else if (s[SW-2:0] >= (SW-1)'({n, {Q_FRAC{1'b0}}})) begin
      t = ONE_Q;
    end else begin
      unique case (n)
        2'd1:    t = TW'(x);
        2'd2:    t = TW'(x >> 1);
        2'd3:    t = TW'(pr >> RECIP_SH);
        default: t = '0;
      endcase
    end
    return t;
  endfunction

  logic en, last_v, ofull;

  ratio_t r1 [3], r2 [3];
  logic [DIV_LAT-1:0] vd_q;
  side_t sd_q [DIV_LAT];

  logic a1_v_q, a2_v_q, p1_v_q, p2_v_q, g1_v_q, g2_v_q;
  geo_t a1_geo_q, a2_geo_q, p1_geo_q;
  logic signed [SW-1:0] s1_q, s2_q, s1, s2;
  logic [1:0] n_q, n;
  logic [TW-1:0] t1_q, t2_q;
  logic a2_vr_q, p1_vr_q, p2_vr_q, g1_vr_q, g2_vr_q;
  logic signed [SCW-1:0] pr1_q [3], pr2_q [3];
  coord_t pa2_q [3], pb2_q [3], pa3_q [3], pb3_q [3], pa4_q [3], pb4_q [3];
  logic [CW-1:0] dm_q [3];
  logic [SQW-1:0] sq_q [3];
  logic [SQW+1:0] sum;
  logic [CW-1:0] root;

  logic [SQ_LAT-1:0] vs_q;
  pt_t pt_q [SQ_LAT];

  out_t       ent_q [2];
  out_t       ent;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign last_v   = vs_q[SQ_LAT-1];
  assign ofull    = cnt_q == 2'd2;
  assign en       = !last_v || !ofull;
  assign in_rdy_o = en;

  for (genvar k = 0; k < 3; k++) begin : g_div
    spc_div u_div1 (.clk_i, .en_i(en), .num_i(mid_i.c1[k]), .den_i(mid_i.cl[k]),
                    .q_o(r1[k]));
    spc_div u_div2 (.clk_i, .en_i(en), .num_i(mid_i.c2[k]), .den_i(mid_i.cl[k]),
                    .q_o(r2[k]));
  end

  always_comb begin
    s1 = '0;
    s2 = '0;
    n  = '0;
    for (int k = 0; k < 3; k++) begin
      if (sd_q[DIV_LAT-1].mask[k]) begin
        s1 = s1 + SW'(r1[k]);
        s2 = s2 + SW'(r2[k]);
        n  = n + 2'd1;
      end
    end
  end

  assign sum = (SQW+2)'(sq_q[0]) + (SQW+2)'(sq_q[1]) + (SQW+2)'(sq_q[2]);

  spc_sqrt u_sqrt (.clk_i, .en_i(en), .x_i(sum[SQW-1:0]), .r_o(root));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q   <= '0;
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
      vs_q   <= '0;
    end else if (en) begin
      vd_q   <= {vd_q[DIV_LAT-2:0], in_vld_i};
      a1_v_q <= vd_q[DIV_LAT-1];
      a2_v_q <= a1_v_q;
      p1_v_q <= a2_v_q;
      p2_v_q <= p1_v_q;
      g1_v_q <= p2_v_q;
      g2_v_q <= g1_v_q;
      vs_q   <= {vs_q[SQ_LAT-2:0], g2_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0].geo  <= mid_i.geo;
      sd_q[0].mask <= mid_i.mask;
      for (int i = 1; i < DIV_LAT; i++) sd_q[i] <= sd_q[i-1];

      a1_geo_q <= sd_q[DIV_LAT-1].geo;
      s1_q     <= s1;
      s2_q     <= s2;
      n_q      <= n;

      a2_geo_q <= a1_geo_q;
      t1_q     <= avg_t(s1_q, n_q);
      t2_q     <= avg_t(s2_q, n_q);
      a2_vr_q  <= n_q != 2'd0;

      p1_geo_q <= a2_geo_q;
      p1_vr_q  <= a2_vr_q;
      p2_vr_q  <= p1_vr_q;
      g1_vr_q  <= p2_vr_q;
      g2_vr_q  <= g1_vr_q;
      for (int k = 0; k < 3; k++) begin
        pr1_q[k] <= $signed({1'b0, t1_q}) * a2_geo_q.d1[k];
        pr2_q[k] <= $signed({1'b0, t2_q}) * a2_geo_q.d2[k];
        pa2_q[k] <= p1_geo_q.as[k] + CW'(pr1_q[k] >>> Q_FRAC);
        pb2_q[k] <= p1_geo_q.bs[k] + CW'(pr2_q[k] >>> Q_FRAC);
        pa3_q[k] <= pa2_q[k];
        pb3_q[k] <= pb2_q[k];
        dm_q[k]  <= (pa2_q[k] >= pb2_q[k]) ? CW'(DW'(pa2_q[k]) - DW'(pb2_q[k]))
                                           : CW'(DW'(pb2_q[k]) - DW'(pa2_q[k]));
        pa4_q[k] <= pa3_q[k];
        pb4_q[k] <= pb3_q[k];
        sq_q[k]  <= SQW'(dm_q[k]) * SQW'(dm_q[k]);
      end

      pt_q[0].pa  <= pa4_q;
      pt_q[0].pb  <= pb4_q;
      pt_q[0].vr  <= g2_vr_q;
      pt_q[0].sat <= sum[SQW+1:SQW] != 2'b00;
      for (int i = 1; i < SQ_LAT; i++) pt_q[i] <= pt_q[i-1];
    end
  end

  always_comb begin
    ent.vres = pt_q[SQ_LAT-1].vr;
    for (int k = 0; k < 3; k++) begin
      ent.na[k] = ent.vres ? pt_q[SQ_LAT-1].pa[k] : '0;
      ent.nb[k] = ent.vres ? pt_q[SQ_LAT-1].pb[k] : '0;
    end
    priority if (!ent.vres) ent.gap = '0;
    else if (pt_q[SQ_LAT-1].sat) ent.gap = '1;
    else ent.gap = root;
  end

  assign do_push = last_v && !ofull;
  assign do_pop  = pop_i && !empty_o;
  assign empty_o = cnt_q == 2'd0;
  assign out_o   = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wp_q] <= ent;
  end

endmodule

`default_nettype wire

// ===== hdl/segment_pair_closest_points.sv =====
// Top level of the segment pair closest points block: configuration port and
// the front end, middle queue and back end. Uses spc_pkg, spc_front, spc_mq, spc_back.
`default_nettype none

// Closest points between two 3D segments in signed Q16.16. One segment pair
// is taken per clock and one result comes out per clock while pop keeps up;
// the delay from push to the result queue is set mostly by the 59-stage ratio
// divider pipeline (56 quotient bits) and the 33-stage square root pipeline.
// The front end (4 stages) and back end stall independently
// through a two-entry queue; results wait in a two-entry output queue.
// The epsilon register at byte address 0 resets to 7.

module segment_pair_closest_points import spc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CW-1:0]     seg_a_start_x_i,
  input  wire logic [CW-1:0]     seg_a_start_y_i,
  input  wire logic [CW-1:0]     seg_a_start_z_i,
  input  wire logic [CW-1:0]     seg_a_end_x_i,
  input  wire logic [CW-1:0]     seg_a_end_y_i,
  input  wire logic [CW-1:0]     seg_a_end_z_i,
  input  wire logic [CW-1:0]     seg_b_start_x_i,
  input  wire logic [CW-1:0]     seg_b_start_y_i,
  input  wire logic [CW-1:0]     seg_b_start_z_i,
  input  wire logic [CW-1:0]     seg_b_end_x_i,
  input  wire logic [CW-1:0]     seg_b_end_y_i,
  input  wire logic [CW-1:0]     seg_b_end_z_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   valid_res_o,
  output logic [CW-1:0]          near_a_x_o,
  output logic [CW-1:0]          near_a_y_o,
  output logic [CW-1:0]          near_a_z_o,
  output logic [CW-1:0]          near_b_x_o,
  output logic [CW-1:0]          near_b_y_o,
  output logic [CW-1:0]          near_b_z_o,
  output logic [CW-1:0]          gap_length_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CW-1:0]     pwdata,
  output logic [CW-1:0]          prdata,
  output logic                   pready
);

  logic [EPS_W-1:0] eps_q;
  logic             sel_eps;
  seg_t             seg;
  logic             mid_vld, mid_full, mid_empty, back_rdy;
  mid_t             mid_in, mid_out;
  out_t             res;

  assign pready  = 1'b1;
  assign sel_eps = paddr[CFG_AW-1:2] == REG_EPS;
  assign prdata  = sel_eps ? {1'b0, eps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && sel_eps) begin
      eps_q <= pwdata[EPS_W-1:0];
    end
  end

  always_comb begin
    seg.as[0] = seg_a_start_x_i;
    seg.as[1] = seg_a_start_y_i;
    seg.as[2] = seg_a_start_z_i;
    seg.ae[0] = seg_a_end_x_i;
    seg.ae[1] = seg_a_end_y_i;
    seg.ae[2] = seg_a_end_z_i;
    seg.bs[0] = seg_b_start_x_i;
    seg.bs[1] = seg_b_start_y_i;
    seg.bs[2] = seg_b_start_z_i;
    seg.be[0] = seg_b_end_x_i;
    seg.be[1] = seg_b_end_y_i;
    seg.be[2] = seg_b_end_z_i;
  end

  spc_front u_front (
    .clk_i, .rst_ni,
    .push_i    (push),
    .full_o    (full),
    .seg_i     (seg),
    .eps_i     (eps_q),
    .mid_vld_o (mid_vld),
    .mid_o     (mid_in),
    .mid_rdy_i (!mid_full)
  );

  spc_mq u_mq (
    .clk_i, .rst_ni,
    .push_i  (mid_vld),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (back_rdy),
    .empty_o (mid_empty),
    .data_o  (mid_out)
  );

  spc_back u_back (
    .clk_i, .rst_ni,
    .in_vld_i (!mid_empty),
    .mid_i    (mid_out),
    .in_rdy_o (back_rdy),
    .empty_o  (empty),
    .pop_i    (pop),
    .out_o    (res)
  );

  assign valid_res_o  = res.vres;
  assign near_a_x_o   = res.na[0];
  assign near_a_y_o   = res.na[1];
  assign near_a_z_o   = res.na[2];
  assign near_b_x_o   = res.nb[0];
  assign near_b_y_o   = res.nb[1];
  assign near_b_z_o   = res.nb[2];
  assign gap_length_o = res.gap;

endmodule

`default_nettype wire

// ===== dv/segment_pair_closest_points_tb.sv =====
// Testbench for segment_pair_closest_points: random and directed segment pairs
// checked against a built-in predictor through a small scoreboard class.
// Depends on spc_pkg and the segment_pair_closest_points RTL.
`default_nettype none

module segment_pair_closest_points_tb;
  import spc_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned ITEMS_PER_PHASE = 400;
  localparam logic [CFG_AW-1:0] EPS_ADDR = CFG_AW'(4 * REG_EPS);
  localparam logic [127:0] RATIO_MAX = 128'h00FF_FFFF_FFFF_FFFF;
  localparam longint Q_ONE = 65536;

  class closest_point_board;
    out_t        pending_q[$];
    logic [30:0] eps;
    int          fails;

    function new();
      eps = EPS_RESET;
      fails = 0;
    endfunction

    function logic signed [127:0] cross_prod(longint u, longint v, longint p, longint q);
      logic signed [127:0] su, sv, sp, sq;
      su = u; sv = v; sp = p; sq = q;
      return su * sv - sp * sq;
    endfunction

    function logic [127:0] mag(logic signed [127:0] x);
      return x[127] ? -x : x;
    endfunction

    function longint ratio_q16(logic signed [127:0] num, logic signed [127:0] den);
      logic [127:0] q;
      q = (mag(num) << 16) / mag(den);
      if (q > RATIO_MAX) q = RATIO_MAX;
      return (num[127] ^ den[127]) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function longint clamp_unit(longint t);
      if (t < 0) return 0;
      if (t > Q_ONE) return Q_ONE;
      return t;
    endfunction

    function logic [31:0] root_floor(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res[31:0];
    endfunction

    function out_t predict_closest(seg_t s);
      out_t r;
      longint a0[3], b0[3], d1[3], d2[3], w[3], pa[3], pb[3];
      longint s1, s2, t1, t2, diff;
      logic signed [127:0] c1, c2, cl;
      logic [127:0] m, acc;
      int n, ia, ib;
      bit sat;
      n = 0; s1 = 0; s2 = 0;
      r.vres = 0; r.gap = 0;
      for (int k = 0; k < 3; k++) begin
        a0[k] = longint'(s.as[k]);
        b0[k] = longint'(s.bs[k]);
        d1[k] = longint'(s.ae[k]) - a0[k];
        d2[k] = longint'(s.be[k]) - b0[k];
        w[k] = b0[k] - a0[k];
        r.na[k] = 0; r.nb[k] = 0;
      end
      for (int k = 0; k < 3; k++) begin
        ia = (k + 1) % 3; ib = (k + 2) % 3;
        c1 = cross_prod(w[ia], d2[ib], w[ib], d2[ia]);
        c2 = cross_prod(w[ia], d1[ib], w[ib], d1[ia]);
        cl = cross_prod(d1[ia], d2[ib], d1[ib], d2[ia]);
        if (mag(cl) > {97'd0, eps}) begin
          s1 += ratio_q16(c1, cl);
          s2 += ratio_q16(c2, cl);
          n++;
        end
      end
      if (n == 0) return r;
      t1 = clamp_unit(s1 / n);
      t2 = clamp_unit(s2 / n);
      acc = 0; sat = 0;
      for (int k = 0; k < 3; k++) begin
        pa[k] = a0[k] + ((t1 * d1[k]) >>> 16);
        pb[k] = b0[k] + ((t2 * d2[k]) >>> 16);
        r.na[k] = pa[k][31:0];
        r.nb[k] = pb[k][31:0];
        diff = pa[k] - pb[k];
        m = diff < 0 ? -diff : diff;
        if (m > 128'hFFFF_FFFF) sat = 1;
        acc += m * m;
      end
      if (acc >= (128'd1 << 64)) sat = 1;
      r.vres = 1;
      r.gap = sat ? 32'hFFFF_FFFF : root_floor(acc[63:0]);
      return r;
    endfunction

    function void note_pair(seg_t s);
      pending_q.insert(pending_q.size(), predict_closest(s));
    endfunction

    function void check_result(out_t act);
      out_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no transaction pending, gap %h", $time, act.gap);
        fails++;
        return;
      end
      e = pending_q.pop_front();
      if (act.vres !== e.vres) begin
        $display("%0t: valid_res exp %b got %b", $time, e.vres, act.vres);
        fails++;
      end
      for (int k = 0; k < 3; k++) begin
        if (act.na[k] !== e.na[k]) begin
          $display("%0t: near_a[%0d] exp %h got %h", $time, k, e.na[k], act.na[k]);
          fails++;
        end
        if (act.nb[k] !== e.nb[k]) begin
          $display("%0t: near_b[%0d] exp %h got %h", $time, k, e.nb[k], act.nb[k]);
          fails++;
        end
      end
      if (act.gap !== e.gap) begin
        $display("%0t: gap_length exp %h got %h", $time, e.gap, act.gap);
        fails++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, push, full, empty, pop;
  logic [CW-1:0] sax, say, saz, sex, sey, sez, sbx, sby, sbz, ebx, eby, ebz;
  logic valid_res_o;
  logic [CW-1:0] near_a_x_o, near_a_y_o, near_a_z_o, near_b_x_o, near_b_y_o, near_b_z_o;
  logic [CW-1:0] gap_length_o, prdata, pwdata;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;

  closest_point_board board;
  seg_t cur_pair;
  int tx_idle, rx_idle, hold_left, stall_cnt;

  segment_pair_closest_points uut (
    .clk_i, .rst_ni, .push, .full,
    .seg_a_start_x_i(sax), .seg_a_start_y_i(say), .seg_a_start_z_i(saz),
    .seg_a_end_x_i(sex), .seg_a_end_y_i(sey), .seg_a_end_z_i(sez),
    .seg_b_start_x_i(sbx), .seg_b_start_y_i(sby), .seg_b_start_z_i(sbz),
    .seg_b_end_x_i(ebx), .seg_b_end_y_i(eby), .seg_b_end_z_i(ebz),
    .empty, .pop, .valid_res_o,
    .near_a_x_o, .near_a_y_o, .near_a_z_o, .near_b_x_o, .near_b_y_o, .near_b_z_o,
    .gap_length_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 0;
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  // transaction monitor and stall watchdog
  always @(posedge clk_i) begin
    out_t act;
    if (rst_ni) begin
      if (push && !full) board.note_pair(cur_pair);
      if (pop && !empty) begin
        act.vres = valid_res_o;
        act.na[0] = near_a_x_o; act.na[1] = near_a_y_o; act.na[2] = near_a_z_o;
        act.nb[0] = near_b_x_o; act.nb[1] = near_b_y_o; act.nb[2] = near_b_z_o;
        act.gap = gap_length_o;
        board.check_result(act);
      end
      if ((push && !full) || (pop && !empty)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt > STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side
  initial begin
    pop = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CW-1:0] data);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_pair(seg_t s);
    if ($urandom_range(99) < tx_idle) begin
      push <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cur_pair <= s;
    sax <= s.as[0]; say <= s.as[1]; saz <= s.as[2];
    sex <= s.ae[0]; sey <= s.ae[1]; sez <= s.ae[2];
    sbx <= s.bs[0]; sby <= s.bs[1]; sbz <= s.bs[2];
    ebx <= s.be[0]; eby <= s.be[1]; ebz <= s.be[2];
    push <= 1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  function automatic seg_t rand_pair();
    seg_t s;
    int kind, lim, mul;
    kind = $urandom_range(9);
    lim = 1 << $urandom_range(4, 24);
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0, 1, 2: begin
          s.as[k] = $urandom; s.ae[k] = $urandom; s.bs[k] = $urandom; s.be[k] = $urandom;
        end
        3: begin
          s.as[k] = pick_extreme(); s.ae[k] = pick_extreme();
          s.bs[k] = pick_extreme(); s.be[k] = pick_extreme();
        end
        default: begin
          s.as[k] = $urandom_range(2 * lim) - lim; s.ae[k] = $urandom_range(2 * lim) - lim;
          s.bs[k] = $urandom_range(2 * lim) - lim; s.be[k] = $urandom_range(2 * lim) - lim;
        end
      endcase
    end
    if (kind >= 7) begin
      // parallel or nearly parallel pair
      mul = $urandom_range(4) - 2;
      for (int k = 0; k < 3; k++) s.be[k] = s.bs[k] + mul * (s.ae[k] - s.as[k]);
      if (kind == 8) s.be[$urandom_range(2)] += $urandom_range(2) - 1;
    end
    if (kind == 6) s.ae = s.as;
    return s;
  endfunction

  function automatic seg_t make_pair(coord_t v[12]);
    seg_t s;
    for (int k = 0; k < 3; k++) begin
      s.as[k] = v[k]; s.ae[k] = v[3 + k]; s.bs[k] = v[6 + k]; s.be[k] = v[9 + k];
    end
    return s;
  endfunction

  initial begin
    logic [30:0] eps_set[4];
    coord_t v[12];
    board = new();
    rst_ni = 0; push = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    {sax, say, saz, sex, sey, sez, sbx, sby, sbz, ebx, eby, ebz} = '0;
    tx_idle = 0; rx_idle = 0; hold_left = 0; stall_cnt = 0;
    eps_set = '{31'd0, 31'h7FFF_FFFF, 31'($urandom_range(1, 1 << 20)), EPS_RESET};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle = (ph == 0) ? 20 : (ph == 1) ? 74 : 0;
      rx_idle = (ph == 0) ? 74 : (ph == 1) ? 20 : 0;
      cfg_write(EPS_ADDR, {1'b0, eps_set[ph]});
      board.eps = eps_set[ph];
      if (ph == 0) begin
        v = '{default: 0}; send_pair(make_pair(v));
        v = '{default: 32'h7FFF_FFFF}; send_pair(make_pair(v));
        v = '{default: 32'h8000_0000}; send_pair(make_pair(v));
        v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_pair(make_pair(v));
        // crossing perpendicular segments
        v = '{-65536, 0, 0, 65536, 0, 0, 0, -65536, 0, 0, 65536, 0};
        send_pair(make_pair(v));
        // skew, one unit apart
        v = '{-65536, 0, 0, 65536, 0, 0, 0, -65536, 65536, 0, 65536, 65536};
        send_pair(make_pair(v));
        // parameters clamp at both ends
        v = '{0, 0, 0, 65536, 0, 0, 327680, -65536, 65536, 327680, 65536, 65536};
        send_pair(make_pair(v));
        v = '{0, 0, 0, 65536, 0, 0, -327680, -65536, 0, -327680, 65536, 0};
        send_pair(make_pair(v));
        // parallel and collinear
        v = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0, 131072, 65536, 0};
        send_pair(make_pair(v));
        v = '{0, 0, 0, 65536, 65536, 0, 131072, 131072, 0, 196608, 196608, 0};
        send_pair(make_pair(v));
        // zero-length segments
        v = '{5, 5, 5, 5, 5, 5, 9, 9, 9, 9, 9, 9};
        send_pair(make_pair(v));
        // tiny cross product, just nonzero
        v = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 1, 0};
        send_pair(make_pair(v));
        // huge ratio, far skew lines
        v = '{0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 1};
        send_pair(make_pair(v));
        // distance overflow
        v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
              32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_pair(make_pair(v));
      end
      if (ph == 2) hold_left = 400;
      repeat (ITEMS_PER_PHASE) send_pair(rand_pair());
      push <= 0;
      while (board.pending_q.size() != 0) @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end
    if (board.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
